[rtl/lomba_pkg.sv]
// Shared types, codes and helper functions for the linked order mover.
// No dependencies; every other file imports this package.
package lomba_pkg;

    localparam int LABEL_W       = 7;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int COUNT_RESET   = 64;
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [1:0]         op_t;
    typedef logic [1:0]         req_code_t;

    // request codes as they arrive on the input channel
    localparam req_code_t REQ_BEFORE = 2'd0;
    localparam req_code_t REQ_AFTER  = 2'd1;
    localparam req_code_t REQ_DUMP   = 2'd2;

    // classified operations carried through the queue
    localparam op_t OP_BEFORE = 2'd0;
    localparam op_t OP_AFTER  = 2'd1;
    localparam op_t OP_DUMP   = 2'd2;
    localparam op_t OP_REJECT = 2'd3;

    localparam logic STAT_DONE   = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    typedef struct packed {
        op_t    op;
        label_t moved;
        label_t anchor;
    } queue_entry_t;

    function automatic label_t clamp_count(label_t value, label_t max_items);
        label_t res;
        if (value < LABEL_W'(2))
            res = LABEL_W'(2);
        else if (value > max_items)
            res = max_items;
        else
            res = value;
        return res;
    endfunction

    // link values of the natural order 1..cnt
    function automatic label_t reset_next(label_t lab, label_t cnt);
        label_t res;
        if (lab < cnt)
            res = lab + LABEL_W'(1);
        else
            res = '0;
        return res;
    endfunction

    function automatic label_t reset_prev(label_t lab);
        return lab - LABEL_W'(1);
    endfunction

endpackage

[rtl/lomba_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on lomba_pkg for the label type.
interface lomba_req_if import lomba_pkg::*; ();
    logic      valid;
    logic      ready;
    req_code_t req_type;
    label_t    moved_item;
    label_t    anchor_item;

    modport source (output valid, output req_type, output moved_item, output anchor_item,
                    input ready);
    modport sink   (input valid, input req_type, input moved_item, input anchor_item,
                    output ready);
endinterface

interface lomba_rsp_if import lomba_pkg::*; ();
    logic   valid;
    logic   ready;
    label_t item_label;
    logic   status;
    logic   last;

    modport source (output valid, output item_label, output status, output last,
                    input ready);
    modport sink   (input valid, input item_label, input status, input last,
                    output ready);
endinterface

[rtl/lomba_front.sv]
// Front end: holds the item count register, accepts requests and classifies them.
// Depends on lomba_pkg and lomba_req_if.
module lomba_front import lomba_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    lomba_req_if.sink    req,
    input  logic         cfg_we,
    input  label_t       cfg_wdata,
    input  logic         q_full,
    output logic         q_push,
    output queue_entry_t q_entry,
    output label_t       item_count
);

    label_t count_reg;
    label_t count_next;
    logic   labels_ok;

    assign count_next = clamp_count(cfg_wdata, LABEL_W'(MAX_ITEMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= clamp_count(LABEL_W'(COUNT_RESET), LABEL_W'(MAX_ITEMS));
        else if (cfg_we)
            count_reg <= count_next;
    end

    assign item_count = count_reg;

    assign labels_ok = (req.moved_item != '0) && (req.anchor_item != '0) &&
                       (req.moved_item <= count_reg) && (req.anchor_item <= count_reg) &&
                       (req.moved_item != req.anchor_item);

    always_comb
    begin
        q_entry.moved  = req.moved_item;
        q_entry.anchor = req.anchor_item;
        case (req.req_type)
            REQ_BEFORE: q_entry.op = labels_ok ? OP_BEFORE : OP_REJECT;
            REQ_AFTER:  q_entry.op = labels_ok ? OP_AFTER : OP_REJECT;
            REQ_DUMP:   q_entry.op = OP_DUMP;
            default:    q_entry.op = OP_REJECT;
        endcase
    end

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

endmodule

[rtl/lomba_queue.sv]
// Short queue of classified requests between front and back end.
// Depends on lomba_pkg for the entry type and depth.
module lomba_queue import lomba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output queue_entry_t head_entry
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [PTR_W-1:0]         wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_next;
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;

    assign full       = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign valid      = (fill_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + FILL_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[rtl/lomba_back.sv]
// Back end: link tables, head pointer, move sequencer, order walk and result register.
// Depends on lomba_pkg and lomba_rsp_if.
module lomba_back import lomba_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  label_t       item_count,
    input  logic         q_valid,
    input  queue_entry_t q_entry,
    output logic         q_pop,
    lomba_rsp_if.source  rsp
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UNL  = 3'd1;
    localparam logic [2:0] ST_W2   = 3'd2;
    localparam logic [2:0] ST_W3   = 3'd3;
    localparam logic [2:0] ST_RES  = 3'd4;
    localparam logic [2:0] ST_DRD  = 3'd5;
    localparam logic [2:0] ST_DEM  = 3'd6;

    function automatic logic [IDX_W-1:0] to_idx(label_t lab);
        label_t t;
        t = lab - LABEL_W'(1);
        return t[IDX_W-1:0];
    endfunction

    // link tables; an entry never written since reset or a count write reads as natural order
    label_t               n_mem [MAX_ITEMS];
    label_t               p_mem [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] n_vld_reg;
    logic [MAX_ITEMS-1:0] p_vld_reg;

    logic [2:0] state_reg, state_next;
    op_t        op_reg, op_next;
    label_t     x_reg, x_next;
    label_t     y_reg, y_next;
    label_t     q_reg, q_next;
    label_t     w_reg, w_next;
    label_t     k_reg, k_next;
    label_t     head_reg, head_next;

    logic   rd_en;
    label_t rd_a_lab, rd_b_lab;
    label_t rd_a_lab_reg, rd_b_lab_reg;
    label_t n_rd_a_reg, n_rd_b_reg, p_rd_a_reg, p_rd_b_reg;
    logic   nv_a_reg, nv_b_reg, pv_a_reg, pv_b_reg;
    label_t na, nb, pa, pb;

    logic   n_we, p_we;
    label_t n_wlab, p_wlab, n_wdata, p_wdata;

    logic   can_push, push, push_status, push_last, fin;
    label_t push_label;

    logic   out_valid_reg;
    label_t out_label_reg;
    logic   out_status_reg;
    logic   out_last_reg;

    // read ports: data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            n_rd_a_reg   <= n_mem[to_idx(rd_a_lab)];
            n_rd_b_reg   <= n_mem[to_idx(rd_b_lab)];
            p_rd_a_reg   <= p_mem[to_idx(rd_a_lab)];
            p_rd_b_reg   <= p_mem[to_idx(rd_b_lab)];
            nv_a_reg     <= n_vld_reg[to_idx(rd_a_lab)];
            nv_b_reg     <= n_vld_reg[to_idx(rd_b_lab)];
            pv_a_reg     <= p_vld_reg[to_idx(rd_a_lab)];
            pv_b_reg     <= p_vld_reg[to_idx(rd_b_lab)];
            rd_a_lab_reg <= rd_a_lab;
            rd_b_lab_reg <= rd_b_lab;
        end
        if (n_we)
            n_mem[to_idx(n_wlab)] <= n_wdata;
        if (p_we)
            p_mem[to_idx(p_wlab)] <= p_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vld_reg <= '0;
            p_vld_reg <= '0;
        end
        else if (cfg_we)
        begin
            n_vld_reg <= '0;
            p_vld_reg <= '0;
        end
        else
        begin
            if (n_we)
                n_vld_reg[to_idx(n_wlab)] <= 1'b1;
            if (p_we)
                p_vld_reg[to_idx(p_wlab)] <= 1'b1;
        end
    end

    assign na = nv_a_reg ? n_rd_a_reg : reset_next(rd_a_lab_reg, item_count);
    assign nb = nv_b_reg ? n_rd_b_reg : reset_next(rd_b_lab_reg, item_count);
    assign pa = pv_a_reg ? p_rd_a_reg : reset_prev(rd_a_lab_reg);
    assign pb = pv_b_reg ? p_rd_b_reg : reset_prev(rd_b_lab_reg);

    assign can_push = !out_valid_reg || rsp.ready;
    assign fin      = ((k_reg + LABEL_W'(1)) == item_count) || (na == '0);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        q_next      = q_reg;
        w_next      = w_reg;
        k_next      = k_reg;
        head_next   = head_reg;
        rd_en       = 1'b0;
        rd_a_lab    = q_entry.moved;
        rd_b_lab    = q_entry.anchor;
        n_we        = 1'b0;
        n_wlab      = x_reg;
        n_wdata     = y_reg;
        p_we        = 1'b0;
        p_wlab      = x_reg;
        p_wdata     = y_reg;
        q_pop       = 1'b0;
        push        = 1'b0;
        push_label  = '0;
        push_status = STAT_DONE;
        push_last   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_entry.op)
                        OP_BEFORE, OP_AFTER:
                        begin
                            // fetch both links of the moved item and of the anchor
                            q_pop      = 1'b1;
                            rd_en      = 1'b1;
                            op_next    = q_entry.op;
                            x_next     = q_entry.moved;
                            y_next     = q_entry.anchor;
                            state_next = ST_UNL;
                        end
                        OP_DUMP:
                        begin
                            q_pop      = 1'b1;
                            w_next     = head_reg;
                            k_next     = '0;
                            state_next = ST_DRD;
                        end
                        default:
                        begin
                            if (can_push)
                            begin
                                q_pop       = 1'b1;
                                push        = 1'b1;
                                push_status = STAT_REJECT;
                            end
                        end
                    endcase
                end
            end
            ST_UNL:
            begin
                // unlink x: pa is its predecessor, na its successor
                if (pa != '0)
                begin
                    n_we    = 1'b1;
                    n_wlab  = pa;
                    n_wdata = na;
                end
                else
                    head_next = na;
                if (na != '0)
                begin
                    p_we    = 1'b1;
                    p_wlab  = na;
                    p_wdata = pa;
                end
                // neighbour of the anchor after the unlink, forwarded where x touched it
                if (op_reg == OP_BEFORE)
                    q_next = (y_reg == na) ? pa : pb;
                else
                    q_next = (y_reg == pa) ? na : nb;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                n_we   = 1'b1;
                n_wlab = x_reg;
                p_we   = 1'b1;
                p_wlab = x_reg;
                if (op_reg == OP_BEFORE)
                begin
                    n_wdata = y_reg;
                    p_wdata = q_reg;
                end
                else
                begin
                    n_wdata = q_reg;
                    p_wdata = y_reg;
                end
                state_next = ST_W3;
            end
            ST_W3:
            begin
                if (op_reg == OP_BEFORE)
                begin
                    p_we    = 1'b1;
                    p_wlab  = y_reg;
                    p_wdata = x_reg;
                    if (q_reg != '0)
                    begin
                        n_we    = 1'b1;
                        n_wlab  = q_reg;
                        n_wdata = x_reg;
                    end
                    else
                        head_next = x_reg;
                end
                else
                begin
                    n_we    = 1'b1;
                    n_wlab  = y_reg;
                    n_wdata = x_reg;
                    if (q_reg != '0)
                    begin
                        p_we    = 1'b1;
                        p_wlab  = q_reg;
                        p_wdata = x_reg;
                    end
                end
                if (can_push)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_RES;
            end
            ST_RES:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DRD:
            begin
                if (w_reg == '0)
                begin
                    // empty walk: one closing item
                    if (can_push)
                    begin
                        push       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_a_lab   = w_reg;
                    state_next = ST_DEM;
                end
            end
            ST_DEM:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    push_label = w_reg;
                    push_last  = fin;
                    if (fin)
                        state_next = ST_IDLE;
                    else
                    begin
                        w_next     = na;
                        k_next     = k_reg + LABEL_W'(1);
                        state_next = ST_DRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= LABEL_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= cfg_we ? LABEL_W'(1) : head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        q_reg  <= q_next;
        w_reg  <= w_next;
        k_reg  <= k_next;
    end

    // result register: frees the sequencer while the consumer stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_label_reg  <= push_label;
            out_status_reg <= push_status;
            out_last_reg   <= push_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.item_label = out_label_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.last       = out_last_reg;

endmodule

[rtl/linked_order_move_before_after_core.sv]
// Move before/after and dump engine over a doubly linked order of labelled items.
// A move reads the links of both items, unlinks the moved item, then makes two splice writes;
// a rejected request gives its result directly; a dump reads and emits its labels one at a time.
// The back end works on one request at a time and takes the next only when it has finished;
// the front end queues further requests meanwhile.
// Reset and count writes restore natural order at once through per-entry valid bits: no sweep.
module linked_order_move_before_after_core import lomba_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lomba_req_if.sink   req,
    lomba_rsp_if.source rsp,
    input  logic        cfg_we,
    input  label_t      cfg_wdata
);

    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    queue_entry_t q_in_entry;
    queue_entry_t q_out_entry;
    label_t       item_count;

    lomba_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in_entry),
        .item_count (item_count)
    );

    lomba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head_entry (q_out_entry)
    );

    lomba_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .item_count (item_count),
        .q_valid    (q_valid),
        .q_entry    (q_out_entry),
        .q_pop      (q_pop),
        .rsp        (rsp)
    );

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_REJECT) |-> (rsp.item_label == '0 && rsp.last))
        else $error("rejected request result malformed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (item_count >= LABEL_W'(2) && item_count <= LABEL_W'(MAX_ITEMS)))
        else $error("item count outside its range after a write");

endmodule

[test/lomba_order_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the linked order mover: keeps its own copy of the link tables.
// Depends on lomba_pkg and the request/result interfaces in lomba_if.sv.
module lomba_order_checker import lomba_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lomba_req_if   req,
    lomba_rsp_if   rsp,
    input  logic   cfg_we,
    input  label_t cfg_wdata,
    output int     errors,
    output int     pending
);

    typedef struct packed {
        label_t lab;
        logic   stat;
        logic   fin;
    } reply_t;

    label_t nxt_of [0:MAX_ITEMS_DEF];
    label_t prv_of [0:MAX_ITEMS_DEF];
    label_t first_lab;
    label_t n_items;
    reply_t due_replies [$];
    int     mism = 0;

    function automatic label_t saturate_count(label_t v);
        label_t c;
        c = v;
        if (v < 2)
            c = label_t'(2);
        else if (v > MAX_ITEMS_DEF)
            c = label_t'(MAX_ITEMS_DEF);
        return c;
    endfunction

    function void natural_order();
        int i;
        for (i = 0; i <= MAX_ITEMS_DEF; i++)
        begin
            nxt_of[i] = '0;
            prv_of[i] = '0;
        end
        for (i = 1; i <= n_items; i++)
        begin
            nxt_of[i] = (i < n_items) ? label_t'(i + 1) : '0;
            prv_of[i] = label_t'(i - 1);
        end
        first_lab = label_t'(1);
    endfunction

    function void detach(label_t x);
        label_t p;
        label_t n;
        p = prv_of[x];
        n = nxt_of[x];
        if (p != 0)
            nxt_of[p] = n;
        else
            first_lab = n;
        if (n != 0)
            prv_of[n] = p;
    endfunction

    function void place_before(label_t x, label_t y);
        label_t q;
        q = prv_of[y];
        prv_of[x] = q;
        nxt_of[x] = y;
        prv_of[y] = x;
        if (q != 0)
            nxt_of[q] = x;
        else
            first_lab = x;
    endfunction

    function void place_after(label_t x, label_t y);
        label_t q;
        q = nxt_of[y];
        nxt_of[x] = q;
        prv_of[x] = y;
        nxt_of[y] = x;
        if (q != 0)
            prv_of[q] = x;
    endfunction

    // Apply one request to the order and queue the results it should produce.
    function void reorder_and_reply(req_code_t t, label_t x, label_t y);
        reply_t r;
        label_t walk;
        label_t nx;
        int     k;
        logic   fin;
        if (t == REQ_DUMP)
        begin
            k    = 0;
            walk = first_lab;
            fin  = 1'b0;
            while (!fin && k < n_items && walk != 0)
            begin
                nx    = nxt_of[walk];
                fin   = (k + 1 == n_items) || (nx == 0);
                r.lab = walk;
                r.stat = STAT_DONE;
                r.fin = fin;
                due_replies.push_back(r);
                k++;
                walk = nx;
            end
            if (k == 0)
            begin
                r.lab = '0;
                r.stat = STAT_DONE;
                r.fin = 1'b1;
                due_replies.push_back(r);
            end
        end
        else
        begin
            r.lab = '0;
            r.fin = 1'b1;
            if (!(t == REQ_BEFORE || t == REQ_AFTER) || x == y || x == 0 || y == 0 ||
                x > n_items || y > n_items)
                r.stat = STAT_REJECT;
            else
            begin
                detach(x);
                if (t == REQ_BEFORE)
                    place_before(x, y);
                else
                    place_after(x, y);
                r.stat = STAT_DONE;
            end
            due_replies.push_back(r);
        end
    endfunction

    function void compare_reply();
        reply_t want;
        if (due_replies.size() == 0)
        begin
            $error("result label %0d status %0d last %0d arrived with nothing outstanding",
                   rsp.item_label, rsp.status, rsp.last);
            mism++;
        end
        else
        begin
            want = due_replies.pop_front();
            if (rsp.item_label !== want.lab)
            begin
                $error("item_label: expected %0d, got %0d", want.lab, rsp.item_label);
                mism++;
            end
            if (rsp.status !== want.stat)
            begin
                $error("status: expected %0d, got %0d", want.stat, rsp.status);
                mism++;
            end
            if (rsp.last !== want.fin)
            begin
                $error("last: expected %0d, got %0d", want.fin, rsp.last);
                mism++;
            end
        end
    endfunction

    // Results are compared before new requests are added: none can leave in its own cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_items = label_t'(COUNT_RESET);
            natural_order();
            due_replies.delete();
            pending <= 0;
            errors  <= mism;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                compare_reply();
            if (cfg_we)
            begin
                n_items = saturate_count(cfg_wdata);
                natural_order();
            end
            if (req.valid && req.ready)
                reorder_and_reply(req.req_type, req.moved_item, req.anchor_item);
            pending <= due_replies.size();
            errors  <= mism;
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Top of the linked order mover testbench: clock, reset, stimulus, stalls and verdict.
// Depends on lomba_pkg, lomba_if.sv, the core and lomba_order_checker.
module tb;
    import lomba_pkg::*;

    localparam req_code_t REQ_SPARE   = 2'd3;
    localparam int        HOLD_CYCLES = 150;
    localparam int        QUIET_LIMIT = 3000;
    localparam int        SETTLE      = 20;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    label_t cfg_wdata;
    int     fails;
    int     open_replies;
    int     quiet = 0;
    bit     calm = 1'b0;
    bit     squeeze = 1'b0;
    label_t live_count;

    lomba_req_if req_ch ();
    lomba_rsp_if rsp_ch ();

    always #6 clk = ~clk;

    linked_order_move_before_after_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lomba_order_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (fails),
        .pending   (open_replies)
    );

    // Result side: random stalls, one long hold when asked, none in the calm stretch.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeeze = 1'b0;
            end
            else if (calm)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic offer(req_code_t t, label_t x, label_t y);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= t;
        req_ch.moved_item  <= x;
        req_ch.anchor_item <= y;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (open_replies != 0);
    endtask

    task automatic write_count(label_t v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (v < 2)
            live_count = label_t'(2);
        else if (v > MAX_ITEMS_DEF)
            live_count = label_t'(MAX_ITEMS_DEF);
        else
            live_count = v;
    endtask

    // Mostly legal moves inside the current count, the rest dumps and rejects.
    task automatic run_random(int n);
        req_code_t t;
        label_t    x;
        label_t    y;
        int        r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            t = ($urandom_range(0, 1) == 0) ? REQ_BEFORE : REQ_AFTER;
            x = label_t'($urandom_range(1, live_count));
            y = label_t'($urandom_range(1, live_count));
            if (r < 8)
            begin
                t = REQ_DUMP;
                x = label_t'($urandom_range(0, 127));
                y = label_t'($urandom_range(0, 127));
            end
            else if (r < 75)
            begin
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 1) == 0)
                    x = label_t'($urandom_range(0, 127));
                else
                    y = label_t'($urandom_range(0, 127));
            end
            else if (r < 90)
                y = x;
            else if (r < 95)
            begin
                t = REQ_SPARE;
                x = label_t'($urandom_range(0, 127));
                y = label_t'($urandom_range(0, 127));
            end
            else
            begin
                x = label_t'($urandom_range(0, 127));
                y = label_t'($urandom_range(0, 127));
            end
            offer(t, x, y);
        end
    endtask

    initial
    begin
        label_t cfg_plan [9] = '{2, 0, 127, 5, 1, 17, 65, 33, 64};
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_DUMP;
        req_ch.moved_item  <= '0;
        req_ch.anchor_item <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        live_count = label_t'(COUNT_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full order: head and tail moves, no-op moves and every reject
        offer(REQ_DUMP, 0, 0);
        offer(REQ_BEFORE, 64, 1);
        offer(REQ_AFTER, 1, 64);
        offer(REQ_AFTER, 2, 63);
        offer(REQ_BEFORE, 3, 4);
        offer(REQ_BEFORE, 5, 5);
        offer(REQ_AFTER, 0, 3);
        offer(REQ_BEFORE, 3, 0);
        offer(REQ_AFTER, 65, 1);
        offer(REQ_BEFORE, 1, 127);
        offer(REQ_SPARE, 10, 20);
        offer(REQ_AFTER, 64, 63);
        offer(REQ_DUMP, 127, 127);

        // two items: swap both ways
        write_count(2);
        offer(REQ_BEFORE, 2, 1);
        offer(REQ_DUMP, 0, 0);
        offer(REQ_AFTER, 2, 1);
        offer(REQ_BEFORE, 1, 3);
        offer(REQ_AFTER, 1, 2);
        offer(REQ_DUMP, 85, 42);

        // fill the block while results are held back
        write_count(64);
        squeeze = 1'b1;
        run_random(40);

        foreach (cfg_plan[p])
        begin
            write_count(cfg_plan[p]);
            if (p == $size(cfg_plan) - 1)
                calm = 1'b1;
            run_random(30);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fails == 0 && open_replies == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
